/* src/dual_lane_crc32c_hash_core_defines.svh */
// Assertion macros used by the top-level core to check itself.
`ifndef DUAL_LANE_CRC32C_HASH_CORE_DEFINES_SVH
`define DUAL_LANE_CRC32C_HASH_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define DLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlc assertion failed");

// Next-cycle implication, checked only out of reset.
`define DLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlc assertion failed");

`endif

/* src/dlc_pkg.sv */
package dlc_pkg;

  localparam logic [31:0] CASTAGNOLI_REFLECTED = 32'h82F6_3B78;
  localparam int unsigned HALF_BITS = 16;
  localparam int unsigned WORD_BITS = 32;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_WORD,
    CMD_TAIL,
    CMD_MISUSE
  } cmd_kind_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] seed;
    logic [15:0] total_length;
    logic [31:0] data_word;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        misuse;
  } out_beat_t;

  // One classified command handed from the front to the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        wide;
    logic        emit;
    logic        lane_two;
    logic [1:0]  tail_cnt;
    logic [31:0] data;
    logic [31:0] seed_one;
    logic [31:0] seed_two;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CASTAGNOLI_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

  // The bit loop is linear in crc and data, so it folds into one XOR matrix.
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c[0] ? ((c >> 1) ^ CASTAGNOLI_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] swap_halves(input logic [31:0] v);
    return {v[HALF_BITS-1:0], v[WORD_BITS-1:HALF_BITS]};
  endfunction

endpackage

/* src/dlc_front.sv */
module dlc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              accept,
  input  dlc_pkg::in_beat_t beat,
  output dlc_pkg::cmd_t     cmd
);

  logic        wide_r;
  logic [13:0] words_r, words_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic        open_r, open_nxt;
  logic [13:0] words_dec;
  logic        zero_len;

  assign words_dec = words_r - 14'd1;
  assign zero_len  = (beat.total_length == 16'd0);

  always_comb begin
    words_nxt    = words_r;
    tail_nxt     = tail_r;
    open_nxt     = open_r;
    cmd.kind     = dlc_pkg::CMD_MISUSE;
    cmd.wide     = wide_r;
    cmd.emit     = 1'b0;
    cmd.lane_two = 1'b0;
    cmd.tail_cnt = tail_r;
    cmd.data     = beat.data_word;
    cmd.seed_one = wide_r ? beat.seed[63:32] : beat.seed[31:0];
    cmd.seed_two = wide_r ? beat.seed[31:0] : 32'd0;
    if (beat.operation == dlc_pkg::OP_START) begin
      cmd.kind  = dlc_pkg::CMD_START;
      cmd.emit  = zero_len;
      words_nxt = beat.total_length[15:2];
      tail_nxt  = beat.total_length[1:0];
      open_nxt  = !zero_len;
    end else if (!open_r) begin
      cmd.kind = dlc_pkg::CMD_MISUSE;
    end else if (words_r != 14'd0) begin
      cmd.kind     = dlc_pkg::CMD_WORD;
      cmd.lane_two = wide_r && !words_dec[0];
      cmd.emit     = (words_dec == 14'd0) && (tail_r == 2'd0);
      words_nxt    = words_dec;
      open_nxt     = !cmd.emit;
    end else begin
      cmd.kind = dlc_pkg::CMD_TAIL;
      cmd.emit = 1'b1;
      tail_nxt = 2'd0;
      open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r  <= 1'b0;
      words_r <= '0;
      tail_r  <= '0;
      open_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        wide_r <= cfg_wdata;
      end
      if (accept) begin
        words_r <= words_nxt;
        tail_r  <= tail_nxt;
        open_r  <= open_nxt;
      end
    end
  end

endmodule

/* src/dlc_cmd_queue.sv */
module dlc_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dlc_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output dlc_pkg::cmd_t      head,
  output dlc_pkg::q_stat_t   stat
);

  dlc_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign head       = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

/* src/dlc_back.sv */
module dlc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dlc_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_take,
  output logic               out_empty,
  input  logic               out_pop,
  output dlc_pkg::out_beat_t out_beat
);

  logic [31:0]        l1_r, l2_r, l1_nxt, l2_nxt;
  dlc_pkg::out_beat_t res_q_r [2];
  dlc_pkg::out_beat_t res;
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r;
  logic               pop_fire, res_push, space;
  logic [1:0]         rem;

  assign pop_fire  = out_pop && (count_r != 2'd0);
  assign space     = (count_r != 2'd2) || pop_fire;
  assign cmd_take  = cmd_valid && space;
  assign res_push  = cmd_take && (cmd.emit || (cmd.kind == dlc_pkg::CMD_MISUSE));
  assign out_empty = (count_r == 2'd0);
  assign out_beat  = res_q_r[rd_ptr_r];

  always_comb begin
    l1_nxt = l1_r;
    l2_nxt = l2_r;
    rem    = 2'd0;
    case (cmd.kind)
      dlc_pkg::CMD_START: begin
        l1_nxt = cmd.seed_one;
        l2_nxt = cmd.seed_two;
      end
      dlc_pkg::CMD_WORD: begin
        if (cmd.lane_two) begin
          l2_nxt = dlc_pkg::crc_word(l2_r, cmd.data);
        end else begin
          l1_nxt = dlc_pkg::crc_word(l1_r, cmd.data);
        end
      end
      dlc_pkg::CMD_TAIL: begin
        // In wide mode, byte i goes to lane two when the bytes left after it are even.
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < cmd.tail_cnt) begin
            rem = cmd.tail_cnt - 2'(i) - 2'd1;
            if (cmd.wide && !rem[0]) begin
              l2_nxt = dlc_pkg::crc_byte(l2_nxt, cmd.data[8*i +: 8]);
            end else begin
              l1_nxt = dlc_pkg::crc_byte(l1_nxt, cmd.data[8*i +: 8]);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd.kind == dlc_pkg::CMD_MISUSE) begin
      res.hash_value = '0;
      res.misuse     = 1'b1;
    end else begin
      res.hash_value = {cmd.wide ? dlc_pkg::swap_halves(l2_nxt) : 32'd0,
                        dlc_pkg::swap_halves(l1_nxt)};
      res.misuse     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r     <= '0;
      l2_r     <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cmd_take) begin
        l1_r <= l1_nxt;
        l2_r <= l2_nxt;
      end
      if (res_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (res_push && !pop_fire) begin
        count_r <= count_r + 2'd1;
      end else if (pop_fire && !res_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

/* src/dual_lane_crc32c_hash_core.sv */
// Dual-lane CRC-32C message hash. A start beat loads the seed and the byte length, data
// beats then bring the whole little-endian words and one last beat the 1 to 3 tail bytes,
// and the finished hash comes out as one result beat; a data beat with no message open
// yields a result with misuse set and a zero hash. The block takes one beat per clock
// cycle while the command queue is not full: each beat is classified by the front in
// the cycle it is accepted, waits in a two-beat command queue, and the back applies one
// full 32-bit CRC step (or the whole tail) per cycle while the result queue has room.
// The beat finishing the message is registered in the command queue, and its result
// then in the result queue. The two-beat result queue lets the input keep flowing while
// a result waits to be popped; only a stalled result queue that fills the command queue
// raises full. The wide_mode register (cfg_wdata) selects 32-bit or 64-bit output and
// should be written while the block is idle.
module dual_lane_crc32c_hash_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  dlc_pkg::in_beat_t  in_beat,
  output logic               out_empty,
  input  logic               out_pop,
  output dlc_pkg::out_beat_t out_beat
);

  `include "dual_lane_crc32c_hash_core_defines.svh"

  dlc_pkg::cmd_t    front_cmd;
  dlc_pkg::cmd_t    head_cmd;
  dlc_pkg::q_stat_t cmd_stat;
  logic             in_accept;
  logic             cmd_take;

  // A beat is taken whenever the command queue has room.
  assign in_full   = cmd_stat.full;
  assign in_accept = in_push && !cmd_stat.full;

  dlc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (in_accept),
    .beat     (in_beat),
    .cmd      (front_cmd)
  );

  dlc_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_accept),
    .push_cmd(front_cmd),
    .pop     (cmd_take),
    .head    (head_cmd),
    .stat    (cmd_stat)
  );

  dlc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (head_cmd),
    .cmd_valid(!cmd_stat.empty),
    .cmd_take (cmd_take),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_beat (out_beat)
  );

  // A misuse result never carries a hash.
  `DLC_ASSERT_NOW(a_misuse_zero, !out_empty && out_beat.misuse, out_beat.hash_value == 64'd0)
  // The input side only stalls while commands are waiting for the back.
  `DLC_ASSERT_NOW(a_full_has_work, in_full, !cmd_stat.empty)
  // With an empty result queue the back drains a command every cycle.
  `DLC_ASSERT_NEXT(a_no_idle_back, out_empty && !cmd_stat.empty && !in_push, !in_full)

endmodule

/* tb/tb_dual_lane_crc32c_hash_core.sv */
// Testbench for the dual-lane CRC-32C hash core.
//
// The sender pushes input beats through the push/full queue port and the receiver
// pops result beats through the empty/pop port. Every accepted input beat goes
// through a local model of the hash, which queues the result beat it expects.
// The result checker compares each popped beat with the oldest expectation.
module tb_dual_lane_crc32c_hash_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Reflected Castagnoli polynomial, as used by the x86 crc32 instruction.
  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

  // The beat finishing a message is registered in the command queue and its result then
  // in the result queue. The block is treated as idle only after a further settling wait.
  localparam int SETTLE_CYCLES = 8;

  // Length of the long receiver hold-off that makes the block fill up.
  localparam int HOLD_CYCLES = 300;

  // Upper bound on the wait for outstanding results at the end of the run.
  localparam int DRAIN_LIMIT = 4000;

  // Beat count at which each random phase ends.
  localparam int PHASE1_END = 430;
  localparam int PHASE2_END = 780;
  localparam int PHASE3_END = 1120;
  localparam int PHASE4_END = 1480;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_push;
  logic               in_full;
  dlc_pkg::in_beat_t  in_beat;
  logic               out_empty;
  logic               out_pop;
  dlc_pkg::out_beat_t out_beat;

  dual_lane_crc32c_hash_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_beat   (in_beat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_beat  (out_beat)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the hash state and of the wide_mode register.
  logic [31:0] lane_one_acc;
  logic [31:0] lane_two_acc;
  logic [13:0] words_pending;
  logic [1:0]  tail_pending;
  logic        msg_open;
  logic        wide_mode_cfg;

  // Result beats that the model has produced and the block has not yet delivered.
  dlc_pkg::out_beat_t hash_expect_q[$];

  // Run control shared between the stimulus and the receiver.
  bit no_idle;
  bit hold_go;
  bit rx_hold;

  int error_count;
  int beats_sent;
  int results_seen;
  int misuse_seen;
  int full_stalls;
  int mode_writes;

  // ---------------------------------------------------------------------------
  // Hash model
  // ---------------------------------------------------------------------------

  // Runs nbits steps of the reflected CRC shift register.
  function automatic logic [31:0] crc32c_advance(input logic [31:0] crc, input int nbits);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < nbits; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Closes the message and queues its hash. Each lane gets its 16-bit halves
  // swapped; in 32-bit mode the upper word of the hash is zero.
  task automatic queue_final_hash();
    dlc_pkg::out_beat_t r;
    r.misuse = 1'b0;
    r.hash_value[31:0]  = {lane_one_acc[15:0], lane_one_acc[31:16]};
    r.hash_value[63:32] = wide_mode_cfg ? {lane_two_acc[15:0], lane_two_acc[31:16]} : 32'd0;
    hash_expect_q.push_back(r);
    msg_open = 1'b0;
  endtask

  // Applies one accepted input beat to the model.
  task automatic predict_hash(input dlc_pkg::in_beat_t b);
    dlc_pkg::out_beat_t r;
    logic [7:0] tail_byte;
    int shift;
    if (b.operation == dlc_pkg::OP_START) begin
      // A start always reloads the lanes, so an open message is simply dropped.
      if (wide_mode_cfg) begin
        lane_one_acc = b.seed[63:32];
        lane_two_acc = b.seed[31:0];
      end else begin
        lane_one_acc = b.seed[31:0];
        lane_two_acc = 32'd0;
      end
      words_pending = b.total_length[15:2];
      tail_pending  = b.total_length[1:0];
      msg_open = 1'b1;
      if (b.total_length == 16'd0) begin
        queue_final_hash();
      end
    end else if (!msg_open) begin
      // Data with no message open: error beat, state untouched.
      r.hash_value = 64'd0;
      r.misuse = 1'b1;
      hash_expect_q.push_back(r);
    end else if (words_pending != 14'd0) begin
      // In wide mode, the lane is chosen by the parity of the word count left after this one.
      words_pending = words_pending - 14'd1;
      if (wide_mode_cfg && !words_pending[0]) begin
        lane_two_acc = crc32c_advance(lane_two_acc ^ b.data_word, 32);
      end else begin
        lane_one_acc = crc32c_advance(lane_one_acc ^ b.data_word, 32);
      end
      if (words_pending == 14'd0 && tail_pending == 2'd0) begin
        queue_final_hash();
      end
    end else begin
      // Tail beat: bytes come from the low end, the unused upper bytes are ignored.
      shift = 0;
      while (tail_pending != 2'd0) begin
        tail_byte = b.data_word[shift +: 8];
        tail_pending = tail_pending - 2'd1;
        if (wide_mode_cfg && !tail_pending[0]) begin
          lane_two_acc = crc32c_advance(lane_two_acc ^ {24'd0, tail_byte}, 8);
        end else begin
          lane_one_acc = crc32c_advance(lane_one_acc ^ {24'd0, tail_byte}, 8);
        end
        shift += 8;
      end
      queue_final_hash();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic dlc_pkg::in_beat_t make_beat(input dlc_pkg::op_t op,
                                                  input logic [63:0] seed,
                                                  input logic [15:0] len,
                                                  input logic [31:0] word);
    dlc_pkg::in_beat_t b;
    b.operation    = op;
    b.seed         = seed;
    b.total_length = len;
    b.data_word    = word;
    return b;
  endfunction

  function automatic logic [63:0] random_seed();
    return {$urandom, $urandom};
  endfunction

  // Offers one beat after a random gap and holds it until the block takes it.
  // Push is left high after the handshake so that back-to-back beats never
  // lower and raise it within the same time step.
  task automatic send_beat(input dlc_pkg::in_beat_t beat);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_beat <= beat;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    predict_hash(beat);
    beats_sent++;
  endtask

  task automatic send_start(input logic [63:0] seed, input logic [15:0] len);
    send_beat(make_beat(dlc_pkg::OP_START, seed, len, $urandom));
  endtask

  task automatic send_data(input logic [31:0] word);
    send_beat(make_beat(dlc_pkg::OP_DATA, random_seed(), 16'($urandom), word));
  endtask

  // Sends a start and its data beats with random content. A non-negative cut stops
  // after that many data beats and leaves the message open if that is short of its end.
  task automatic send_message(input logic [63:0] seed, input int len, input int cut);
    int n_data;
    n_data = (len + 3) / 4;
    send_start(seed, 16'(len));
    for (int i = 0; i < n_data && (cut < 0 || i < cut); i++) begin
      send_data($urandom);
    end
  endtask

  // Waits until every expected result has been popped and the pipeline has
  // had time to absorb beats that produce no result.
  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_wide_mode(input logic mode);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    wide_mode_cfg = mode;
    mode_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and result check
  // ---------------------------------------------------------------------------

  // The long hold-off is timed here, in cycles, apart from the receiver.
  initial begin : hold_timer
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Pops result beats after random gaps and checks each one against the
  // oldest expectation. Pop stays high between back-to-back beats.
  initial begin : result_checker
    dlc_pkg::out_beat_t want;
    int gap;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (gap > 0 || rx_hold) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
        while (rx_hold) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      results_seen++;
      if (hash_expect_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none, actual hash %h misuse %b",
                 $time, out_beat.hash_value, out_beat.misuse);
      end else begin
        want = hash_expect_q.pop_front();
        if (want.misuse) misuse_seen++;
        if (out_beat.hash_value !== want.hash_value) begin
          error_count++;
          $display("%0t: hash_value mismatch, expected %h, actual %h",
                   $time, want.hash_value, out_beat.hash_value);
        end
        if (out_beat.misuse !== want.misuse) begin
          error_count++;
          $display("%0t: misuse mismatch, expected %b, actual %b",
                   $time, want.misuse, out_beat.misuse);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, both operations and the named corner cases in both modes.
  task automatic test_directed();
    // Data right after reset finds no message open.
    send_data(32'hFFFF_FFFF);
    // Zero-length messages answer on the start beat itself.
    send_start(64'd0, 16'd0);
    send_start(64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    // A single tail byte; the three upper bytes must be ignored.
    send_start(random_seed(), 16'd1);
    send_data(32'hFFFF_FFFF);
    send_start(64'hFFFF_FFFF_FFFF_FFFF, 16'd4);
    send_data(32'd0);
    send_start(64'd0, 16'd7);
    send_data(32'hFFFF_FFFF);
    send_data(32'h00A5_5A3C);
    send_start(random_seed(), 16'd2);
    send_data($urandom);
    // The longest message is abandoned by the next start after two words.
    send_start(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_data($urandom);
    send_data($urandom);
    send_message(random_seed(), 5, -1);
    // Once the message has closed, data is misuse again.
    send_data(32'd0);

    write_wide_mode(1'b1);
    send_start(64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    send_message(random_seed(), 8, -1);
    send_message(64'hFFFF_FFFF_0000_0000, 11, -1);
    send_message(64'h0000_0000_FFFF_FFFF, 1, -1);
    send_data($urandom);
    send_message(random_seed(), 3, -1);
  endtask

  // The mode is read on every beat, so a write while a message is open
  // changes the lane steering and the result form for the rest of it.
  task automatic test_mode_switch();
    write_wide_mode(1'b1);
    send_start(random_seed(), 16'd12);
    send_data($urandom);
    write_wide_mode(1'b0);
    send_data($urandom);
    send_data($urandom);

    send_start(random_seed(), 16'd6);
    send_data($urandom);
    write_wide_mode(1'b1);
    send_data($urandom);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going
  // at full rate, so the result and command queues fill and full is raised.
  task automatic test_backpressure();
    // The last beat must not be offered again while the hold-off starts.
    @(negedge clk);
    in_push <= 1'b0;
    no_idle = 1'b1;
    hold_go = 1'b1;
    wait (rx_hold);
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_message(random_seed(), $urandom_range(1, 9), -1);
      else send_start(random_seed(), 16'd0);
    end
    no_idle = 1'b0;
  endtask

  // One random phase. Most of the traffic is complete messages with random
  // content; the rest is stray data, abandoned messages and mode changes.
  task automatic run_random_phase(input int beat_target, input bit allow_mode_change);
    int pick;
    int len;
    while (beats_sent < beat_target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_data($urandom);
      end else if (pick < 14) begin
        // Any 16-bit length, cut after at most four data beats; unless that ends it, the next start drops it.
        send_message(random_seed(), $urandom_range(0, 65535), $urandom_range(0, 4));
      end else if (pick < 17 && allow_mode_change) begin
        write_wide_mode(1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 16);
        else if (pick < 95) len = $urandom_range(17, 120);
        else len = $urandom_range(121, 600);
        send_message(random_seed(), len, -1);
      end
    end
  endtask

  task automatic test_random();
    write_wide_mode(1'b0);
    run_random_phase(PHASE1_END, 1'b0);
    write_wide_mode(1'b1);
    run_random_phase(PHASE2_END, 1'b0);
    // A stretch with no idling on either side.
    no_idle = 1'b1;
    run_random_phase(PHASE3_END, 1'b0);
    no_idle = 1'b0;
    run_random_phase(PHASE4_END, 1'b1);
  endtask

  // Waits, with a limit, for the last results and reports the outcome.
  task automatic finish_run();
    @(negedge clk);
    in_push <= 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && hash_expect_q.size() != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hash_expect_q.size() != 0) begin
      error_count += hash_expect_q.size();
      $display("%0t: results never delivered, expected %0d more, actual 0",
               $time, hash_expect_q.size());
    end
    $display("Sent %0d input beats and checked %0d result beats (%0d misuse).",
             beats_sent, results_seen, misuse_seen);
    $display("Wrote wide_mode %0d times; input was held off by full for %0d cycles.",
             mode_writes, full_stalls);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_push   = 1'b0;
    in_beat   = '0;
    no_idle   = 1'b0;
    hold_go   = 1'b0;
    error_count  = 0;
    beats_sent   = 0;
    results_seen = 0;
    misuse_seen  = 0;
    full_stalls  = 0;
    mode_writes  = 0;

    // Model state after reset.
    lane_one_acc  = 32'd0;
    lane_two_acc  = 32'd0;
    words_pending = 14'd0;
    tail_pending  = 2'd0;
    msg_open      = 1'b0;
    wide_mode_cfg = 1'b0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_mode_switch();
    test_backpressure();
    test_random();
    finish_run();
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #20ms;
    $display("%0t: timeout with %0d results outstanding", $time, hash_expect_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/dlc_pkg.sv
src/dlc_front.sv
src/dlc_cmd_queue.sv
src/dlc_back.sv
src/dual_lane_crc32c_hash_core.sv
tb/tb_dual_lane_crc32c_hash_core.sv
